/* rtl/rational_arithmetic_unit_defines.svh */
// Assertion macros shared by the checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// An implication that must hold at every edge outside reset.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// An implication checked in the cycle after the antecedent.
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/rau_pkg.sv */
package rau_pkg;
  localparam int OperandWidthDef = 16;
  localparam int ResW = 33;
  localparam int GcdCntW = 7;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_RED = 4'd4,
    OP_EQ = 4'd5, OP_NE = 4'd6, OP_LT = 4'd7, OP_LE = 4'd8, OP_GT = 4'd9,
    OP_GE = 4'd10, OP_ISZ = 4'd11, OP_INC = 4'd12, OP_DEC = 4'd13
  } op_t;

  // Datapath commands, one action per cycle.
  typedef struct packed {
    logic load;      // capture operands
    logic mul;       // multiplier step (index sel)
    logic [1:0] msel;
    logic form;      // build numerator/denominator from products
    logic ginit;     // start gcd
    logic gstep;     // one gcd step
    logic fin;       // normalize and register the result
  } rau_cmd_t;

  typedef struct packed {
    logic need_red;
    logic gdone;
  } rau_sts_t;
endpackage

/* rtl/rational_arithmetic_unit.sv */
// Sequence: operands are loaded, four products are formed on the shared multiplier
// and the result is registered; subtract or reduce first runs a gcd (fixed window)
// and a bit-serial divide. A start word is taken only when idle; busy is high otherwise.
// Reset: synchronous active-low rst_n clears the controller and the strobe.
// The receiver cannot stall: out_valid marks each result for one cycle only.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OperandWidthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [3:0] in_operation,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic out_valid,
  output logic signed [ResW-1:0] out_res_num,
  output logic signed [ResW-1:0] out_res_den,
  output logic out_truth,
  output logic out_zero_den
);
  // The controller sequences the shared multiplier, the gcd and the divide.
  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .out_valid(out_valid)
  );

  // The datapath holds operands, products, the gcd and the result register.
  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .in_operation(in_operation), .in_a_num(in_a_num),
    .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .cmd(cmd), .sts(sts), .res_num(out_res_num), .res_den(out_res_den),
    .truth(out_truth), .zero_den(out_zero_den)
  );
endmodule

/* rtl/rau_datapath.sv */
module rau_datapath import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OperandWidthDef
) (
  input  logic clk,
  input  logic [3:0] in_operation,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  input  rau_cmd_t cmd,
  output rau_sts_t sts,
  output logic signed [ResW-1:0] res_num,
  output logic signed [ResW-1:0] res_den,
  output logic truth,
  output logic zero_den
);
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int MW = ResW + 1;

  logic [3:0] op_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [ResW-1:0] n_r, d_r;
  logic [MW-1:0] gx_r, gy_r;
  logic [GcdCntW-1:0] sh_r;
  logic signed [OPERAND_WIDTH-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic [MW-1:0] gx_nxt, gy_nxt, diff;
  logic signed [ResW-1:0] n_nxt, d_nxt, qn, qd;
  logic [MW-1:0] g;
  logic [ResW-1:0] mn, md;
  logic lt_r, eqp_r, tr;
  logic signed [ResW-1:0] rn_nxt, rd_nxt;
  logic gdone;
  logic need_red;

  // One shared multiplier forms the four products in turn.
  always_comb begin
    case (cmd.msel)
      2'd0: begin ma = an_r; mb = bd_r; end
      2'd1: begin ma = bn_r; mb = ad_r; end
      2'd2: begin ma = ad_r; mb = (op_r == OP_DIV) ? bn_r : bd_r; end
      default: begin ma = an_r; mb = bn_r; end
    endcase
    prod = PW'(ma * mb);
  end

  function automatic logic signed [ResW-1:0] sx(input logic signed [PW-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[ResW-1:0];
  endfunction

  function automatic logic signed [ResW-1:0] sxo(input logic signed [OPERAND_WIDTH-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[ResW-1:0];
  endfunction

  always_comb begin
    n_nxt = '0;
    d_nxt = '0;
    case (op_r)
      OP_ADD: begin n_nxt = sx(p0_r) + sx(p1_r); d_nxt = sx(p2_r); end
      OP_SUB: begin n_nxt = sx(p0_r) - sx(p1_r); d_nxt = sx(p2_r); end
      OP_MUL: begin n_nxt = sx(p3_r); d_nxt = sx(p2_r); end
      OP_DIV: begin n_nxt = sx(p0_r); d_nxt = sx(p2_r); end
      OP_RED: begin n_nxt = sxo(an_r); d_nxt = sxo(ad_r); end
      OP_INC: begin n_nxt = sxo(an_r) + sxo(ad_r); d_nxt = sxo(ad_r); end
      OP_DEC: begin n_nxt = sxo(an_r) - sxo(ad_r); d_nxt = sxo(ad_r); end
      default: begin n_nxt = '0; d_nxt = '0; end
    endcase
  end

  assign mn = n_r[ResW-1] ? ResW'(-n_r) : n_r;
  assign md = d_r[ResW-1] ? ResW'(-d_r) : d_r;

  // Stein's gcd: one shift, or a subtract and shift, per step.
  always_comb begin
    gx_nxt = gx_r;
    gy_nxt = gy_r;
    diff = (gx_r > gy_r) ? gx_r - gy_r : gy_r - gx_r;
    if (!gx_r[0] && !gy_r[0]) begin
      gx_nxt = gx_r >> 1;
      gy_nxt = gy_r >> 1;
    end else if (!gx_r[0]) begin
      gx_nxt = gx_r >> 1;
    end else if (!gy_r[0]) begin
      gy_nxt = gy_r >> 1;
    end else begin
      gx_nxt = (gx_r < gy_r) ? gx_r : gy_r;
      gy_nxt = diff >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      an_r <= in_a_num; ad_r <= in_a_den; bn_r <= in_b_num; bd_r <= in_b_den;
    end
    if (cmd.mul) begin
      case (cmd.msel)
        2'd0: p0_r <= prod;
        2'd1: p1_r <= prod;
        2'd2: p2_r <= prod;
        default: p3_r <= prod;
      endcase
    end
    if (cmd.form) begin
      n_r <= n_nxt;
      d_r <= d_nxt;
      lt_r <= p0_r < p1_r;
      eqp_r <= p0_r == p1_r;
    end
    if (cmd.ginit) begin
      gx_r <= MW'(mn);
      gy_r <= MW'(md);
      sh_r <= '0;
    end else if (cmd.gstep && gx_r != '0 && gy_r != '0) begin
      if (!gx_r[0] && !gy_r[0]) sh_r <= sh_r + 1'b1;
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
  end

  assign g = ((gx_r == '0) ? gy_r : gx_r) << sh_r;
  // Both magnitudes are divided by the gcd in a separate quotient unit, which, after a
  // fixed wait window for the gcd, produces one quotient bit per cycle while gstep is held.
  logic [ResW-1:0] qn_u, qd_u;
  rau_div #(.W(ResW)) u_div (
    .clk(clk), .start(cmd.ginit), .a(mn), .b(md), .g(g),
    .gdone(gdone), .gst(cmd.gstep),
    .qa(qn_u), .qb(qd_u)
  );
  assign qn = n_r[ResW-1] ? -$signed(qn_u) : $signed(qn_u);
  assign qd = d_r[ResW-1] ? -$signed(qd_u) : $signed(qd_u);

  assign need_red = (op_r == OP_SUB || op_r == OP_RED) && d_r != '0 && n_r != '0;
  assign sts = '{need_red: need_red, gdone: gdone};

  always_comb begin
    rn_nxt = n_r;
    rd_nxt = d_r;
    tr = 1'b0;
    case (op_r)
      OP_SUB, OP_RED: begin
        if (d_r != '0 && n_r == '0) rd_nxt = ResW'(1);
        else if (d_r != '0) begin
          rn_nxt = qn;
          rd_nxt = qd;
          if (qn == qd) begin rn_nxt = ResW'(1); rd_nxt = ResW'(1); end
        end
      end
      OP_ADD, OP_MUL, OP_DIV, OP_INC, OP_DEC: ;
      OP_EQ: tr = (an_r == bn_r) && (ad_r == bd_r);
      OP_NE: tr = !((an_r == bn_r) && (ad_r == bd_r));
      OP_LT: tr = lt_r;
      OP_LE: tr = lt_r || eqp_r;
      OP_GT: tr = !(lt_r || eqp_r);
      OP_GE: tr = !lt_r;
      OP_ISZ: tr = (an_r == '0) || (ad_r == '0);
      default: ;
    endcase
  end

  logic arith;
  assign arith = (op_r <= OP_RED) || op_r == OP_INC || op_r == OP_DEC;

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_num <= arith ? rn_nxt : '0;
      res_den <= arith ? rd_nxt : '0;
      truth <= tr;
      zero_den <= arith && rd_nxt == '0;
    end
  end
endmodule

/* rtl/rau_div.sv */
module rau_div import rau_pkg::*; #(
  parameter int W = ResW
) (
  input  logic clk,
  input  logic start,
  input  logic gst,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W:0] g,
  output logic gdone,
  output logic [W-1:0] qa,
  output logic [W-1:0] qb
);
  // Restoring division of both terms by the gcd, one quotient bit per cycle while gst
  // is held, started after phase 0 has counted gst steps through a fixed wait for the gcd.
  localparam int CW = $clog2(W + 1) + 1;
  logic [W-1:0] ra_r, rb_r, na_r, nb_r;
  logic [W:0] div_r;
  logic [CW-1:0] cnt_r;
  logic [1:0] ph_r;
  logic [W:0] ta, tb;
  logic [GcdCntW-1:0] wait_r;

  assign ta = {ra_r, na_r[W-1]} ;
  assign tb = {rb_r, nb_r[W-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      ph_r <= 2'd0;
      wait_r <= '0;
      na_r <= a; nb_r <= b;
      ra_r <= '0; rb_r <= '0;
      qa <= '0; qb <= '0;
      cnt_r <= '0;
    end else if (gst) begin
      if (ph_r == 2'd0) begin
        wait_r <= wait_r + 1'b1;
        if (wait_r == GcdCntW'(2 * W + 2)) begin
          ph_r <= 2'd1;
          div_r <= g;
        end
      end else if (ph_r == 2'd1) begin
        na_r <= na_r << 1;
        nb_r <= nb_r << 1;
        if (ta >= div_r) begin ra_r <= W'(ta - div_r); qa <= {qa[W-2:0], 1'b1}; end
        else begin ra_r <= W'(ta); qa <= {qa[W-2:0], 1'b0}; end
        if (tb >= div_r) begin rb_r <= W'(tb - div_r); qb <= {qb[W-2:0], 1'b1}; end
        else begin rb_r <= W'(tb); qb <= {qb[W-2:0], 1'b0}; end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) ph_r <= 2'd2;
      end
    end
  end
  assign gdone = (ph_r == 2'd2);
endmodule

/* rtl/rau_ctrl.sv */
module rau_ctrl import rau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  rau_sts_t sts,
  output rau_cmd_t cmd,
  output logic busy,
  output logic out_valid
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_FORM = 7'b0000100,
    S_GINI = 7'b0001000, S_GCD = 7'b0010000, S_FIN = 7'b0100000,
    S_OUT = 7'b1000000
  } st_t;
  st_t st_r, st_nxt;
  logic [1:0] m_r, m_nxt;
  logic v_r;

  always_comb begin
    st_nxt = st_r;
    m_nxt = m_r;
    cmd = '0;
    cmd.msel = m_r;
    case (st_r)
      S_IDLE: if (start) begin cmd.load = 1'b1; st_nxt = S_MUL; m_nxt = '0; end
      S_MUL: begin
        cmd.mul = 1'b1;
        m_nxt = m_r + 1'b1;
        if (m_r == 2'd3) st_nxt = S_FORM;
      end
      S_FORM: begin cmd.form = 1'b1; st_nxt = S_GINI; end
      S_GINI: begin
        if (sts.need_red) begin cmd.ginit = 1'b1; st_nxt = S_GCD; end
        else st_nxt = S_FIN;
      end
      S_GCD: begin cmd.gstep = 1'b1; if (sts.gdone) st_nxt = S_FIN; end
      S_FIN: begin cmd.fin = 1'b1; st_nxt = S_OUT; end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      m_r <= '0;
      v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      m_r <= m_nxt;
      v_r <= cmd.fin;
    end
  end
  assign busy = (st_r != S_IDLE);
  assign out_valid = v_r;
endmodule

/* rtl/rau_checker.sv */
`include "rational_arithmetic_unit_defines.svh"
module rau_checker import rau_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_truth,
  input logic out_zero_den,
  input logic [ResW-1:0] out_res_den
);
  `RAU_ASSERT_NXT(a_start_busy, start && !busy, busy, "accept did not raise busy")
  `RAU_ASSERT_NXT(a_strobe_one, out_valid, !out_valid, "strobe longer than a cycle")
  `RAU_ASSERT_IMP(a_zd, out_valid && out_zero_den, out_res_den == '0, "zero_den mismatch")
  `RAU_ASSERT_IMP(a_truth, out_valid && out_truth, out_res_den == '0 && !out_zero_den, "truth with arithmetic")
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_truth(out_truth), .out_zero_den(out_zero_den), .out_res_den(out_res_den)
);
